// ----- rtl/core/assert_macros.svh -----
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: label");

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed: label");

`endif

// ----- rtl/core/hed_pkg.sv -----
// types, constants and name table of the html entity decoder
package hed_pkg;

  localparam int unsigned MaxEntityLen = 16;
  localparam int unsigned NameMax      = 4;
  localparam int unsigned NumNames     = 5;

  localparam logic [7:0] ChAmp  = 8'h26;
  localparam logic [7:0] ChSemi = 8'h3b;

  localparam logic [7:0] NameText [NumNames][NameMax] = '{
    '{8'h61, 8'h6d, 8'h70, 8'h00},  // amp
    '{8'h6c, 8'h74, 8'h00, 8'h00},  // lt
    '{8'h67, 8'h74, 8'h00, 8'h00},  // gt
    '{8'h71, 8'h75, 8'h6f, 8'h74},  // quot
    '{8'h23, 8'h33, 8'h39, 8'h00}   // #39
  };
  localparam logic [2:0] NameLen [NumNames] = '{3'd3, 3'd2, 3'd2, 3'd4, 3'd3};
  localparam logic [7:0] NameRepl [NumNames] = '{8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27};

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
    logic       truncated;
  } out_item_t;

  // control broadcast to every buffer cell
  typedef struct packed {
    logic       clear;
    logic       shift;
    logic       append;
    logic [7:0] byte_val;
  } cell_ctl_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] repl;
  } match_t;

endpackage

// ----- rtl/core/hed_cell.sv -----
// one byte cell of the entity name buffer chain
module hed_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hed_pkg::cell_ctl_t ctl_i,
  input  logic              prev_occ_i,
  input  logic              next_occ_i,
  input  logic [7:0]        next_data_i,
  output logic              occ_o,
  output logic [7:0]        data_o
);
  import hed_pkg::*;

  logic       occ_q, occ_d;
  logic [7:0] data_q, data_d;

  always_comb begin
    occ_d  = occ_q;
    data_d = data_q;
    priority if (ctl_i.clear) begin
      occ_d = 1'b0;
    end else if (ctl_i.shift) begin
      occ_d  = next_occ_i;
      data_d = next_data_i;
    end else if (ctl_i.append && prev_occ_i && !occ_q) begin
      // first free cell of the chain takes the byte
      occ_d  = 1'b1;
      data_d = ctl_i.byte_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign occ_o  = occ_q;
  assign data_o = data_q;
endmodule

// ----- rtl/core/hed_match.sv -----
// compares the head cells of the buffer against the fixed entity names
module hed_match (
  input  logic [hed_pkg::NameMax-1:0][7:0] data_i,
  input  logic [hed_pkg::NameMax:0]        occ_i,
  input  logic                             ovf_i,
  output hed_pkg::match_t                  match_o
);
  import hed_pkg::*;

  always_comb begin
    logic ok;
    match_o = '0;
    for (int i = 0; i < NumNames; i++) begin
      ok = occ_i[NameLen[i] - 3'd1] && !occ_i[NameLen[i]];
      for (int j = 0; j < NameMax; j++) begin
        if (j < NameLen[i]) begin
          ok = ok && (data_i[j] == NameText[i][j]);
        end
      end
      if (ok && !match_o.hit) begin
        match_o.hit  = 1'b1;
        match_o.repl = NameRepl[i];
      end
    end
    // an overflowed name never matches
    if (ovf_i) begin
      match_o.hit = 1'b0;
    end
  end
endmodule

// ----- rtl/core/html_entity_decoder_core.sv -----
// top level of the html entity decoder: control, output register and cell chain
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/in_stall_o   | in_item_i  (in_char, end_of_text)
//  out     | output    | out_valid_o/out_stall_i | out_item_o (out_char, last_of_run, truncated)
//
// plain bytes, an opening '&' and name bytes are taken in ST_RUN whenever the output register can load
// a matched entity gives one item in the cycle after its ';'
// a missed entity replays len + 2 items, one per cycle while the output is not stalled, input stalled meanwhile
// the replay walks the cell chain: each replay step shifts the chain one byte toward its head
// reset empties the chain at once; no clearing pass
// a stalled output holds its item; input is taken only when the output register frees
module html_entity_decoder_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hed_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hed_pkg::out_item_t out_item_o
);
  import hed_pkg::*;
  `include "assert_macros.svh"

  // sequencer codes
  localparam logic [1:0] ST_RUN  = 2'd0;  // taking input bytes
  localparam logic [1:0] ST_BODY = 2'd1;  // replaying buffered name bytes
  localparam logic [1:0] ST_SEMI = 2'd2;  // replaying the closing ';'

  logic [1:0] state_q, state_d;
  logic       in_entity_q, in_entity_d;
  logic       ovf_q, ovf_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;

  cell_ctl_t                    ctl;
  logic [MaxEntityLen-1:0]      occ;
  logic [MaxEntityLen-1:0][7:0] cell_data;
  logic [NameMax:0]             head_occ;
  match_t                       match;

  logic can_load;
  logic in_accept;

  // output register is free, or being emptied this cycle
  assign can_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_RUN) && can_load);
  assign in_accept  = in_valid_i && !in_stall_o;

  // chain of buffer cells: cell 0 is the oldest byte and the replay head
  for (genvar k = 0; k < MaxEntityLen; k++) begin : g_cell
    logic       prev_occ;
    logic       next_occ;
    logic [7:0] next_data;
    if (k == 0) begin : g_first
      assign prev_occ = 1'b1;
    end else begin : g_mid
      assign prev_occ = occ[k-1];
    end
    if (k == MaxEntityLen - 1) begin : g_last
      assign next_occ  = 1'b0;
      assign next_data = 8'h00;
    end else begin : g_inner
      assign next_occ  = occ[k+1];
      assign next_data = cell_data[k+1];
    end
    hed_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .prev_occ_i  (prev_occ),
      .next_occ_i  (next_occ),
      .next_data_i (next_data),
      .occ_o       (occ[k]),
      .data_o      (cell_data[k])
    );
  end

  // occupancy of the head cells, one beyond the longest name
  for (genvar k = 0; k <= NameMax; k++) begin : g_head
    if (k < MaxEntityLen) begin : g_real
      assign head_occ[k] = occ[k];
    end else begin : g_none
      assign head_occ[k] = 1'b0;
    end
  end

  hed_match u_match (
    .data_i  (cell_data[NameMax-1:0]),
    .occ_i   (head_occ),
    .ovf_i   (ovf_q),
    .match_o (match)
  );

  always_comb begin
    state_d      = state_q;
    in_entity_d  = in_entity_q;
    ovf_d        = ovf_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    ctl          = '0;
    ctl.byte_val = in_item_i.in_char;

    unique case (state_q)
      ST_RUN: begin
        if (in_accept) begin
          if (!in_entity_q) begin
            if (in_item_i.in_char == ChAmp) begin
              // open an entity; the chain is already empty here
              in_entity_d = 1'b1;
              ovf_d       = 1'b0;
            end else begin
              out_valid_d       = 1'b1;
              out_d.out_char    = in_item_i.in_char;
              out_d.last_of_run = 1'b1;
              out_d.truncated   = 1'b0;
            end
          end else if (in_item_i.in_char == ChSemi) begin
            in_entity_d = 1'b0;
            out_valid_d = 1'b1;
            if (match.hit) begin
              out_d.out_char    = match.repl;
              out_d.last_of_run = 1'b1;
              out_d.truncated   = 1'b0;
              ctl.clear         = 1'b1;
              ovf_d             = 1'b0;
            end else begin
              // miss: replay '&', then the name, then ';'
              out_d.out_char    = ChAmp;
              out_d.last_of_run = 1'b0;
              out_d.truncated   = ovf_q;
              state_d           = occ[0] ? ST_BODY : ST_SEMI;
            end
          end else begin
            // name byte: append, or mark overflow once the chain is full
            if (occ[MaxEntityLen-1]) begin
              ovf_d = 1'b1;
            end else begin
              ctl.append = 1'b1;
            end
          end
          // entity still open at end of text is dropped
          if (in_item_i.end_of_text && in_entity_d) begin
            in_entity_d = 1'b0;
            ovf_d       = 1'b0;
            ctl.clear   = 1'b1;
          end
        end
      end
      ST_BODY: begin
        if (can_load) begin
          out_valid_d       = 1'b1;
          out_d.out_char    = cell_data[0];
          out_d.last_of_run = 1'b0;
          out_d.truncated   = ovf_q;
          ctl.shift         = 1'b1;
          if (!occ[1]) begin
            state_d = ST_SEMI;
          end
        end
      end
      ST_SEMI: begin
        if (can_load) begin
          out_valid_d       = 1'b1;
          out_d.out_char    = ChSemi;
          out_d.last_of_run = 1'b1;
          out_d.truncated   = ovf_q;
          ovf_d             = 1'b0;
          state_d           = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      in_entity_q <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_entity_q <= in_entity_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload needs no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // occupied cells always form one run from the head of the chain
  `ASSERT_CLK(a_occ_run, clk_i, rst_ni, ((occ >> 1) & ~occ) == '0)
  // input is held off for the whole replay
  `ASSERT_CLK(a_replay_stall, clk_i, rst_ni, (state_q == ST_RUN) || in_stall_o)
  // a replay body step always has a byte at the head cell
  `ASSERT_CLK(a_body_head, clk_i, rst_ni, (state_q != ST_BODY) || occ[0])
  // the closing ';' ends the run of items
  `ASSERT_NEXT(a_semi_last, clk_i, rst_ni, (state_q == ST_SEMI) && can_load,
               out_valid_o && out_item_o.last_of_run && (out_item_o.out_char == ChSemi))
endmodule

// ----- verif/hed_stream_checker.sv -----
// checker for the html entity decoder: watches both channels, predicts and compares
`timescale 1ns / 100ps

module hed_stream_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  hed_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  hed_pkg::out_item_t out_item_i,
  output int                 fail_cnt_o,
  output int                 pend_cnt_o
);

  localparam logic [7:0] Amp  = 8'h26;
  localparam logic [7:0] Semi = 8'h3b;

  // own copy of the decoder state
  logic       in_ent = 1'b0;
  logic [7:0] name_buf [hed_pkg::MaxEntityLen];
  logic [4:0] name_len = '0;
  logic       name_ovf = 1'b0;

  hed_pkg::out_item_t decoded_q [$];
  int                 mismatches = 0;

  assign fail_cnt_o = mismatches;
  assign pend_cnt_o = decoded_q.size();

  // {hit, replacement} for the buffered name
  function automatic logic [8:0] name_lookup();
    logic [8:0] res;
    res = '0;
    case (name_len)
      5'd2: begin
        if (name_buf[0] == "l" && name_buf[1] == "t") res = {1'b1, "<"};
        else if (name_buf[0] == "g" && name_buf[1] == "t") res = {1'b1, ">"};
      end
      5'd3: begin
        if (name_buf[0] == "a" && name_buf[1] == "m" && name_buf[2] == "p")
          res = {1'b1, "&"};
        else if (name_buf[0] == "#" && name_buf[1] == "3" && name_buf[2] == "9")
          res = {1'b1, "'"};
      end
      5'd4: begin
        if (name_buf[0] == "q" && name_buf[1] == "u" && name_buf[2] == "o" &&
            name_buf[3] == "t")
          res = {1'b1, "\""};
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  function automatic void push_decoded(input logic [7:0] ch, input logic last,
                                       input logic trunc);
    hed_pkg::out_item_t e;
    e.out_char    = ch;
    e.last_of_run = last;
    e.truncated   = trunc;
    decoded_q.push_back(e);
  endfunction

  task automatic decode_byte(input hed_pkg::in_item_t it);
    logic [8:0] m;
    logic       trunc;
    m = '0;
    if (!in_ent) begin
      if (it.in_char == Amp) begin
        in_ent   = 1'b1;
        name_len = '0;
        name_ovf = 1'b0;
      end else begin
        push_decoded(it.in_char, 1'b1, 1'b0);
      end
    end else if (it.in_char == Semi) begin
      in_ent = 1'b0;
      if (!name_ovf) m = name_lookup();
      if (m[8]) begin
        push_decoded(m[7:0], 1'b1, 1'b0);
      end else begin
        // replay the entity unchanged, as far as the buffer holds it
        trunc = name_ovf;
        push_decoded(Amp, 1'b0, trunc);
        for (int j = 0; j < name_len; j++) push_decoded(name_buf[j], 1'b0, trunc);
        push_decoded(Semi, 1'b1, trunc);
      end
      name_len = '0;
      name_ovf = 1'b0;
    end else begin
      if (name_len < hed_pkg::MaxEntityLen) begin
        name_buf[name_len[3:0]] = it.in_char;
        name_len                = name_len + 5'd1;
      end else begin
        name_ovf = 1'b1;
      end
    end
    if (it.end_of_text && in_ent) begin
      in_ent   = 1'b0;
      name_len = '0;
      name_ovf = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ent   = 1'b0;
      name_len = '0;
      name_ovf = 1'b0;
      decoded_q.delete();
    end else begin
      // results first: an item taken at this edge cannot have caused one yet
      if (out_valid_i && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected item: char %02h last %0d trunc %0d",
                     out_item_i.out_char, out_item_i.last_of_run, out_item_i.truncated);
          mismatches++;
        end else begin
          if (out_item_i.out_char != decoded_q[0].out_char ||
              out_item_i.last_of_run != decoded_q[0].last_of_run ||
              out_item_i.truncated != decoded_q[0].truncated) begin
            if (mismatches < 10)
              $display("mismatch: exp char %02h last %0d trunc %0d, got %02h %0d %0d",
                       decoded_q[0].out_char, decoded_q[0].last_of_run,
                       decoded_q[0].truncated, out_item_i.out_char,
                       out_item_i.last_of_run, out_item_i.truncated);
            mismatches++;
          end
          void'(decoded_q.pop_front());
        end
      end
      if (in_valid_i && !in_stall_i) decode_byte(in_item_i);
    end
  end

endmodule

// ----- verif/tb_html_entity_decoder_core.sv -----
// testbench top of the html entity decoder: stimulus, receiver and verdict
`timescale 1ns / 100ps

module tb_html_entity_decoder_core;

  // slowest run: ~500 items, each up to 18 results under receiver stalls,
  // plus the long hold-off; this is several times that
  localparam int CycleLimit  = 300000;
  localparam int RandomItems = 450;
  localparam int HoldCycles  = 400;
  localparam int TailCycles  = 40;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_stall_o;
  hed_pkg::in_item_t  in_item     = '0;
  logic               out_valid_o;
  logic               out_stall   = 1'b0;
  hed_pkg::out_item_t out_item_o;

  int  fail_cnt;
  int  pend_cnt;
  int  sent      = 0;
  // calm: no idling on either side; hold_req: ask the receiver for a long hold-off
  logic calm     = 1'b0;
  logic hold_req = 1'b0;

  string known_names [5] = '{"amp", "lt", "gt", "quot", "#39"};

  always #5 clk_i = ~clk_i;

  html_entity_decoder_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o)
  );

  hed_stream_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_i  (out_item_o),
    .fail_cnt_o  (fail_cnt),
    .pend_cnt_o  (pend_cnt)
  );

  // offer one item, with a random idle gap in front, and wait until it is taken
  task automatic send_item(input logic [7:0] ch, input logic eot);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= '{in_char: ch, end_of_text: eot};
    @(posedge clk_i);
    // stall is read before this edge's updates, so this is the accept test
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  // eot goes on the last byte of the string
  task automatic send_text(input string s, input logic eot);
    for (int i = 0; i < s.len(); i++) send_item(s[i], eot && (i == s.len() - 1));
  endtask

  // '&', the name bytes and ';'; cut >= 0 ends the text at that position instead
  task automatic send_entity(input logic [7:0] body [$], input int cut, input logic eot);
    int total;
    logic [7:0] ch;
    total = body.size() + 2;
    for (int p = 0; p < total; p++) begin
      if (p == 0) ch = 8'h26;
      else if (p == total - 1) ch = 8'h3b;
      else ch = body[p - 1];
      if (cut == p) begin
        send_item(ch, 1'b1);
        return;
      end
      send_item(ch, (p == total - 1) ? eot : 1'b0);
    end
  endtask

  // any byte that does not close the entity
  function automatic logic [7:0] name_char();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == hed_pkg::ChSemi) b = 8'h3a;
    return b;
  endfunction

  // receiver: random stalls, and a long hold-off counted here on request
  initial begin : rx_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 17);
      end
    end
  end

  // overall cycle limit
  initial begin : watchdog
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc > CycleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [7:0] body [$];
    int         pick;
    int         len;
    int         k;
    int         base;
    string      nm;
    logic       hold_done;
    logic       pause_done;

    hold_done  = 1'b0;
    pause_done = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: byte extremes, the names quot and #39, empty entity,
    // '&' inside an entity, entity still open at end of text
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b1);
    send_text("&quot;", 1'b0);
    send_text("&#39;", 1'b0);
    send_text("&;", 1'b0);
    send_text("&x&;", 1'b0);
    send_text("&lt", 1'b1);
    send_item(8'h41, 1'b0);

    base = sent;
    k    = 0;
    while (sent < base + RandomItems) begin
      // a stretch of back-to-back traffic on both sides
      calm = (sent >= base + 320) && (sent < base + 400);

      // receiver holds off while items keep coming, so the block backs up
      if (!hold_done && sent >= base + 150) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
      end
      // sender pauses until the block has drained
      if (!pause_done && sent >= base + 260) begin
        pause_done = 1'b1;
        in_valid  <= 1'b0;
        @(negedge clk_i);
        while (pend_cnt != 0) @(negedge clk_i);
        @(posedge clk_i);
      end

      // first rounds force every name and the buffer-size boundary
      if (k < 5) pick = 30;
      else if (k < 8) pick = 85;
      else pick = $urandom_range(99);

      body.delete();
      if (pick < 25) begin
        // plain byte, any value
        send_item(8'($urandom_range(255)), $urandom_range(15) == 0);
      end else if (pick < 60) begin
        // well-formed known name
        nm = known_names[(k < 5) ? k : $urandom_range(4)];
        for (int i = 0; i < nm.len(); i++) body.push_back(nm[i]);
        send_entity(body, -1, $urandom_range(9) == 0);
      end else if (pick < 72) begin
        // unknown name, short
        len = $urandom_range(6);
        repeat (len) body.push_back(name_char());
        send_entity(body, -1, $urandom_range(9) == 0);
      end else if (pick < 80) begin
        // near miss of a known name
        nm = known_names[$urandom_range(4)];
        for (int i = 0; i < nm.len(); i++) body.push_back(nm[i]);
        case ($urandom_range(2))
          0: void'(body.pop_back());
          1: body.push_back(name_char());
          default: body[$urandom_range(body.size() - 1)] = name_char();
        endcase
        send_entity(body, -1, 1'b0);
      end else if (pick < 88) begin
        // around the buffer capacity: exact fit and overflow
        if (k == 5) len = hed_pkg::MaxEntityLen;
        else if (k == 6) len = hed_pkg::MaxEntityLen + 1;
        else if (k == 7) len = hed_pkg::MaxEntityLen + 4;
        else len = $urandom_range(hed_pkg::MaxEntityLen + 4, hed_pkg::MaxEntityLen - 2);
        repeat (len) body.push_back(name_char());
        send_entity(body, -1, $urandom_range(7) == 0);
      end else if (pick < 95) begin
        // entity cut short by end of text
        nm = known_names[$urandom_range(4)];
        for (int i = 0; i < nm.len(); i++) body.push_back(nm[i]);
        if ($urandom_range(1)) repeat ($urandom_range(18)) body.push_back(name_char());
        send_entity(body, $urandom_range(body.size()), 1'b0);
      end else begin
        // noise: stray '&' and ';' mixed with random bytes
        repeat ($urandom_range(4, 1)) begin
          case ($urandom_range(2))
            0: send_item(hed_pkg::ChAmp, $urandom_range(3) == 0);
            1: send_item(hed_pkg::ChSemi, $urandom_range(3) == 0);
            default: send_item(8'($urandom_range(255)), $urandom_range(3) == 0);
          endcase
        end
      end
      k++;
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    // drain, then give a late stray result time to show up
    @(negedge clk_i);
    while (pend_cnt != 0) @(negedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (fail_cnt == 0 && pend_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
